// File: rtl/lvhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvhs_pkg
// Shared types and constants of the load variance host selector.
// ----------------------------------------------------------------------------
package lvhs_pkg;

    localparam int MAX_HOSTS_DEF  = 64;
    localparam int LOAD_BITS_DEF  = 16;
    localparam int COORD_BITS_DEF = 16;

    localparam int ID_W        = 6;
    localparam int RULE_W      = 3;
    localparam int BAL_W       = 24;
    localparam int DEV_W       = 4;
    localparam int M2_W        = 2 * DEV_W;
    localparam int HIST_CNT_W  = 24;
    localparam int HIST_SUM_W  = 2 * BAL_W;
    localparam int HIST_SQ_W   = 64;

    // datapath of the shared mul/div unit; holds every product of the flow
    localparam int ACC_W = 2 * HIST_SUM_W;
    localparam int LEN_W = 7;

    localparam logic [DEV_W-1:0]      DEV_MULT_RESET = DEV_W'(2);
    localparam logic [HIST_CNT_W-1:0] HIST_CNT_MAX   = {HIST_CNT_W{1'b1}};

    typedef enum logic [RULE_W-1:0] {
        RULE_SHORTCUT = 3'd0,
        RULE_LEAST    = 3'd1,
        RULE_NEAREST  = 3'd2,
        RULE_SINGLE   = 3'd3,
        RULE_NONE     = 3'd4
    } rule_t;

    typedef enum logic {
        UOP_MUL = 1'b0,
        UOP_DIV = 1'b1
    } uop_t;

    typedef struct packed {
        logic             start;
        uop_t             op;
        logic [LEN_W-1:0] len;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// File: rtl/lvhs_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvhs_muldiv
// Iterative shift-add multiplier and restoring divider on one shared adder.
// ----------------------------------------------------------------------------
module lvhs_muldiv (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lvhs_pkg::unit_req_t       req,
    input  logic [lvhs_pkg::ACC_W-1:0] opa,
    input  logic [lvhs_pkg::ACC_W-1:0] opb,
    output lvhs_pkg::unit_stat_t      stat,
    output logic [lvhs_pkg::ACC_W-1:0] result
);
    import lvhs_pkg::*;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] a_reg;
    logic [ACC_W-1:0] b_reg;
    logic [LEN_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    uop_t             op_reg;

    logic             is_div;
    logic [ACC_W-1:0] rem_sh;
    logic [ACC_W-1:0] add_x;
    logic [ACC_W-1:0] add_y;
    logic [ACC_W:0]   sum;

    assign is_div = (op_reg == UOP_DIV);
    assign rem_sh = {acc_reg[ACC_W-2:0], a_reg[ACC_W-1]};
    assign add_x  = is_div ? rem_sh : acc_reg;
    assign add_y  = is_div ? ~b_reg : a_reg;
    // divide: carry out set means no borrow on rem - divisor
    assign sum    = {1'b0, add_x} + {1'b0, add_y} + {{ACC_W{1'b0}}, is_div};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            op_reg   <= req.op;
            cnt_reg  <= req.len;
            acc_reg  <= '0;
            a_reg    <= opa;
            b_reg    <= opb;
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            if (is_div)
            begin
                acc_reg <= sum[ACC_W] ? sum[ACC_W-1:0] : rem_sh;
                a_reg   <= {a_reg[ACC_W-2:0], sum[ACC_W]};
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_reg <= sum[ACC_W-1:0];
                end
                a_reg <= {a_reg[ACC_W-2:0], 1'b0};
                b_reg <= {1'b0, b_reg[ACC_W-1:1]};
            end
            cnt_reg <= cnt_reg - LEN_W'(1);
            if (cnt_reg == LEN_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign result    = is_div ? a_reg : acc_reg;

endmodule

// File: rtl/load_variance_host_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_variance_host_selector
// Picks a host per request from a run of candidate items by load variance,
// history threshold and station distance.
// ----------------------------------------------------------------------------
//  channel   signals                                   handshake
//  -------   ---------------------------------------   -------------------------
//  item      host_id .. last_host                      start & !busy
//  result    host_found chosen_host rule_used balance  result_valid, 1 cycle
//  config    cfg_wr_data (deviation_multiplier)        cfg_wr_en
//
//  A non-final item, a request already served and a shortcut are handled
//  in idle without raising busy. A final item runs the sequencer on the
//  shared mul/div unit: up to 12 multiplies (len = multiplier width, 7..48)
//  and one divide (len = numerator width, 45 at default); the unit's adder
//  works one bit per cycle. busy is high meanwhile.
//  rst_n clears request and history state and sets the multiplier to 2.
//  The receiver cannot stall: a result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module load_variance_host_selector #(
    parameter int MAX_HOSTS  = lvhs_pkg::MAX_HOSTS_DEF,
    parameter int LOAD_BITS  = lvhs_pkg::LOAD_BITS_DEF,
    parameter int COORD_BITS = lvhs_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [lvhs_pkg::ID_W-1:0]    host_id,
    input  logic                         can_allocate,
    input  logic                         offers_service,
    input  logic                         needs_service,
    input  logic [LOAD_BITS-1:0]         host_load,
    input  logic                         has_station,
    input  logic signed [COORD_BITS-1:0] station_x,
    input  logic signed [COORD_BITS-1:0] station_y,
    input  logic signed [COORD_BITS-1:0] vehicle_x,
    input  logic signed [COORD_BITS-1:0] vehicle_y,
    input  logic                         last_host,
    input  logic                         cfg_wr_en,
    input  logic [lvhs_pkg::DEV_W-1:0]   cfg_wr_data,
    output logic                         result_valid,
    output logic                         host_found,
    output logic [lvhs_pkg::ID_W-1:0]    chosen_host,
    output logic [lvhs_pkg::RULE_W-1:0]  rule_used,
    output logic [lvhs_pkg::BAL_W-1:0]   balance_degree
);
    import lvhs_pkg::*;

    localparam int KW   = $clog2(MAX_HOSTS + 1);      // eligible count
    localparam int OW   = $clog2(MAX_HOSTS);          // arrival order
    localparam int S1W  = LOAD_BITS + OW;
    localparam int S2W  = 2 * LOAD_BITS + OW;
    localparam int NW   = KW + S2W;                   // K*S2 - S1^2
    localparam int PRE  = (2 * LOAD_BITS >= BAL_W) ? 0 : BAL_W - 2 * LOAD_BITS;
    localparam int POST = (2 * LOAD_BITS >= BAL_W) ? 2 * LOAD_BITS - BAL_W : 0;
    localparam int NUMW = NW + PRE;
    localparam int K2W  = 2 * KW;
    localparam int DW   = COORD_BITS + 1;             // |station - vehicle|
    localparam int DAW  = 2 * DW + 1;                 // squared distance

    typedef enum logic [4:0] {
        ST_IDLE, ST_VMUL1, ST_VMUL2, ST_VSUB, ST_VDIV, ST_VSQ, ST_HIST,
        ST_TNV, ST_TD, ST_TDD, ST_TNQ, ST_TSS, ST_TCLAMP, ST_TRHS, ST_TCMP,
        ST_DXA, ST_DYA, ST_DXB, ST_DYB, ST_PICK
    } state_t;

    state_t state_reg;
    logic   issued_reg;

    logic [DEV_W-1:0]      dev_mult_reg;
    logic [KW-1:0]         count_reg;
    logic [S1W-1:0]        lsum_reg;
    logic [S2W-1:0]        lsq_reg;
    logic                  req_done_reg;
    logic [HIST_CNT_W-1:0] hcnt_reg;
    logic [HIST_SUM_W-1:0] hsum_reg;
    logic [HIST_SQ_W-1:0]  hsq_reg;

    // two lowest-loaded eligible hosts; written before read
    logic [LOAD_BITS-1:0]         e_load [2];
    logic [ID_W-1:0]              e_id   [2];
    logic                         e_sta  [2];
    logic signed [COORD_BITS-1:0] e_sx   [2];
    logic signed [COORD_BITS-1:0] e_sy   [2];
    logic [OW-1:0]                e_ord  [2];

    logic signed [COORD_BITS-1:0] vx_reg;
    logic signed [COORD_BITS-1:0] vy_reg;

    logic [ACC_W-1:0] t0_reg;
    logic [ACC_W-1:0] t1_reg;
    logic [ACC_W-1:0] t2_reg;
    logic [K2W-1:0]   k2_reg;
    logic [BAL_W-1:0] v_reg;
    logic [DAW-1:0]   da_reg;
    logic [DAW-1:0]   db_reg;

    logic             res_valid_reg;
    logic             res_found_reg;
    logic [ID_W-1:0]  res_host_reg;
    rule_t            res_rule_reg;
    logic [BAL_W-1:0] res_bal_reg;

    // shared unit
    unit_req_t        u_req;
    unit_stat_t       u_stat;
    logic [ACC_W-1:0] u_a;
    logic [ACC_W-1:0] u_b;
    logic [ACC_W-1:0] u_result;
    logic             u_arith;

    lvhs_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (u_req),
        .opa    (u_a),
        .opb    (u_b),
        .stat   (u_stat),
        .result (u_result)
    );

    function automatic logic [DW-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [DW-1:0] d;
        d = DW'(a) - DW'(b);
        abs_diff = d[DW-1] ? DW'(-d) : DW'(d);
    endfunction

    logic                 accept;
    logic                 ins;
    logic                 lt0;
    logic                 lt1;
    logic [KW-1:0]        count_after;
    logic [2*LOAD_BITS-1:0] load_sq;
    logic [M2_W-1:0]      m2;
    logic [DW-1:0]        dxa, dya, dxb, dyb;
    logic [ACC_W-1:0]     quo_sh;
    logic [HIST_SQ_W:0]   hsq_sum;
    logic                 pick_b;

    assign accept      = start && !busy;
    assign ins         = can_allocate && offers_service && (count_reg < KW'(MAX_HOSTS));
    assign lt0         = host_load < e_load[0];
    assign lt1         = host_load < e_load[1];
    assign count_after = count_reg + KW'(ins);
    assign load_sq     = (2*LOAD_BITS)'(host_load) * (2*LOAD_BITS)'(host_load);
    assign m2          = M2_W'(dev_mult_reg) * M2_W'(dev_mult_reg);
    assign dxa         = abs_diff(e_sx[0], vx_reg);
    assign dya         = abs_diff(e_sy[0], vy_reg);
    assign dxb         = abs_diff(e_sx[1], vx_reg);
    assign dyb         = abs_diff(e_sy[1], vy_reg);
    assign quo_sh      = u_result >> POST;
    assign hsq_sum     = {1'b0, hsq_reg} + (HIST_SQ_W + 1)'(t0_reg[HIST_SUM_W-1:0]);
    // later arrival wins only on strictly smaller distance
    assign pick_b      = (db_reg < da_reg) || ((db_reg == da_reg) && (e_ord[1] < e_ord[0]));

    // operand selection per sequencer step
    always_comb
    begin
        u_arith = 1'b1;
        u_req.op  = UOP_MUL;
        u_req.len = '0;
        u_a = '0;
        u_b = '0;
        unique case (state_reg)
            ST_VMUL1:
            begin
                u_a = ACC_W'(lsq_reg);
                u_b = ACC_W'(count_reg);
                u_req.len = LEN_W'(KW);
            end
            ST_VMUL2:
            begin
                u_a = ACC_W'(lsum_reg);
                u_b = ACC_W'(lsum_reg);
                u_req.len = LEN_W'(S1W);
            end
            ST_VDIV:
            begin
                u_req.op  = UOP_DIV;
                u_a = ACC_W'(t0_reg[NW-1:0]) << (ACC_W - NW);
                u_b = ACC_W'(k2_reg);
                u_req.len = LEN_W'(NUMW);
            end
            ST_VSQ:
            begin
                u_a = ACC_W'(v_reg);
                u_b = ACC_W'(v_reg);
                u_req.len = LEN_W'(BAL_W);
            end
            ST_TNV:
            begin
                u_arith = (hcnt_reg >= HIST_CNT_W'(2));
                u_a = ACC_W'(v_reg);
                u_b = ACC_W'(hcnt_reg);
                u_req.len = LEN_W'(HIST_CNT_W);
            end
            ST_TDD:
            begin
                u_a = t0_reg;
                u_b = t0_reg;
                u_req.len = LEN_W'(HIST_SUM_W);
            end
            ST_TNQ:
            begin
                u_a = ACC_W'(hsq_reg);
                u_b = ACC_W'(hcnt_reg);
                u_req.len = LEN_W'(HIST_CNT_W);
            end
            ST_TSS:
            begin
                u_a = ACC_W'(hsum_reg);
                u_b = ACC_W'(hsum_reg);
                u_req.len = LEN_W'(HIST_SUM_W);
            end
            ST_TRHS:
            begin
                u_a = t0_reg;
                u_b = ACC_W'(m2);
                u_req.len = LEN_W'(M2_W);
            end
            ST_DXA:
            begin
                u_a = ACC_W'(dxa);
                u_b = ACC_W'(dxa);
                u_req.len = LEN_W'(DW);
            end
            ST_DYA:
            begin
                u_a = ACC_W'(dya);
                u_b = ACC_W'(dya);
                u_req.len = LEN_W'(DW);
            end
            ST_DXB:
            begin
                u_a = ACC_W'(dxb);
                u_b = ACC_W'(dxb);
                u_req.len = LEN_W'(DW);
            end
            ST_DYB:
            begin
                u_a = ACC_W'(dyb);
                u_b = ACC_W'(dyb);
                u_req.len = LEN_W'(DW);
            end
            default:
            begin
                u_arith = 1'b0;
            end
        endcase
        u_req.start = u_arith && !issued_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            dev_mult_reg  <= DEV_MULT_RESET;
            count_reg     <= '0;
            lsum_reg      <= '0;
            lsq_reg       <= '0;
            req_done_reg  <= 1'b0;
            hcnt_reg      <= '0;
            hsum_reg      <= '0;
            hsq_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                dev_mult_reg <= cfg_wr_data;
            end
            if (u_stat.done)
            begin
                issued_reg <= 1'b0;
            end
            else if (u_req.start)
            begin
                issued_reg <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        vx_reg <= vehicle_x;
                        vy_reg <= vehicle_y;
                        if (req_done_reg)
                        begin
                            if (last_host)
                            begin
                                count_reg    <= '0;
                                lsum_reg     <= '0;
                                lsq_reg      <= '0;
                                req_done_reg <= 1'b0;
                            end
                        end
                        else if (can_allocate && !needs_service)
                        begin
                            res_valid_reg <= 1'b1;
                            res_found_reg <= 1'b1;
                            res_host_reg  <= host_id;
                            res_rule_reg  <= RULE_SHORTCUT;
                            res_bal_reg   <= '0;
                            if (last_host)
                            begin
                                count_reg <= '0;
                                lsum_reg  <= '0;
                                lsq_reg   <= '0;
                            end
                            else
                            begin
                                req_done_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            if (ins)
                            begin
                                if (count_reg == KW'(0) || lt0)
                                begin
                                    if (count_reg != KW'(0))
                                    begin
                                        e_load[1] <= e_load[0];
                                        e_id[1]   <= e_id[0];
                                        e_sta[1]  <= e_sta[0];
                                        e_sx[1]   <= e_sx[0];
                                        e_sy[1]   <= e_sy[0];
                                        e_ord[1]  <= e_ord[0];
                                    end
                                    e_load[0] <= host_load;
                                    e_id[0]   <= host_id;
                                    e_sta[0]  <= has_station;
                                    e_sx[0]   <= station_x;
                                    e_sy[0]   <= station_y;
                                    e_ord[0]  <= count_reg[OW-1:0];
                                end
                                else if (count_reg == KW'(1) || lt1)
                                begin
                                    e_load[1] <= host_load;
                                    e_id[1]   <= host_id;
                                    e_sta[1]  <= has_station;
                                    e_sx[1]   <= station_x;
                                    e_sy[1]   <= station_y;
                                    e_ord[1]  <= count_reg[OW-1:0];
                                end
                                count_reg <= count_after;
                                lsum_reg  <= lsum_reg + S1W'(host_load);
                                lsq_reg   <= lsq_reg + S2W'(load_sq);
                            end
                            if (last_host)
                            begin
                                if (count_after < KW'(2))
                                begin
                                    v_reg     <= '0;
                                    t0_reg    <= '0;
                                    state_reg <= ST_HIST;
                                end
                                else
                                begin
                                    state_reg <= ST_VMUL1;
                                end
                            end
                        end
                    end
                end
                ST_VMUL1:
                begin
                    if (u_stat.done)
                    begin
                        t0_reg    <= u_result;
                        state_reg <= ST_VMUL2;
                    end
                end
                ST_VMUL2:
                begin
                    if (u_stat.done)
                    begin
                        t1_reg    <= u_result;
                        state_reg <= ST_VSUB;
                    end
                end
                ST_VSUB:
                begin
                    t0_reg    <= t0_reg - t1_reg;
                    k2_reg    <= K2W'(count_reg) * K2W'(count_reg);
                    state_reg <= ST_VDIV;
                end
                ST_VDIV:
                begin
                    if (u_stat.done)
                    begin
                        v_reg     <= quo_sh[BAL_W-1:0];
                        state_reg <= ST_VSQ;
                    end
                end
                ST_VSQ:
                begin
                    if (u_stat.done)
                    begin
                        t0_reg    <= u_result;
                        state_reg <= ST_HIST;
                    end
                end
                ST_HIST:
                begin
                    // history freezes once the count is full
                    if (hcnt_reg < HIST_CNT_MAX)
                    begin
                        hcnt_reg <= hcnt_reg + HIST_CNT_W'(1);
                        hsum_reg <= hsum_reg + HIST_SUM_W'(v_reg);
                        hsq_reg  <= hsq_sum[HIST_SQ_W] ? {HIST_SQ_W{1'b1}}
                                                       : hsq_sum[HIST_SQ_W-1:0];
                    end
                    if (count_reg < KW'(2))
                    begin
                        res_valid_reg <= 1'b1;
                        res_found_reg <= (count_reg == KW'(1));
                        res_host_reg  <= (count_reg == KW'(1)) ? e_id[0] : '0;
                        res_rule_reg  <= (count_reg == KW'(1)) ? RULE_SINGLE : RULE_NONE;
                        res_bal_reg   <= v_reg;
                        count_reg     <= '0;
                        lsum_reg      <= '0;
                        lsq_reg       <= '0;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_TNV;
                    end
                end
                ST_TNV:
                begin
                    if (hcnt_reg < HIST_CNT_W'(2))
                    begin
                        state_reg <= ST_DXA;
                    end
                    else if (u_stat.done)
                    begin
                        t0_reg    <= u_result;
                        state_reg <= ST_TD;
                    end
                end
                ST_TD:
                begin
                    if (t0_reg <= ACC_W'(hsum_reg))
                    begin
                        state_reg <= ST_DXA;
                    end
                    else
                    begin
                        t0_reg    <= t0_reg - ACC_W'(hsum_reg);
                        state_reg <= ST_TDD;
                    end
                end
                ST_TDD:
                begin
                    if (u_stat.done)
                    begin
                        t1_reg    <= u_result;
                        state_reg <= ST_TNQ;
                    end
                end
                ST_TNQ:
                begin
                    if (u_stat.done)
                    begin
                        t0_reg    <= u_result;
                        state_reg <= ST_TSS;
                    end
                end
                ST_TSS:
                begin
                    if (u_stat.done)
                    begin
                        t2_reg    <= u_result;
                        state_reg <= ST_TCLAMP;
                    end
                end
                ST_TCLAMP:
                begin
                    t0_reg    <= (t0_reg > t2_reg) ? t0_reg - t2_reg : '0;
                    state_reg <= ST_TRHS;
                end
                ST_TRHS:
                begin
                    if (u_stat.done)
                    begin
                        t0_reg    <= u_result;
                        state_reg <= ST_TCMP;
                    end
                end
                ST_TCMP:
                begin
                    if (t1_reg > t0_reg)
                    begin
                        res_valid_reg <= 1'b1;
                        res_found_reg <= 1'b1;
                        res_host_reg  <= e_id[0];
                        res_rule_reg  <= RULE_LEAST;
                        res_bal_reg   <= v_reg;
                        count_reg     <= '0;
                        lsum_reg      <= '0;
                        lsq_reg       <= '0;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_DXA;
                    end
                end
                ST_DXA:
                begin
                    if (u_stat.done)
                    begin
                        t0_reg    <= u_result;
                        state_reg <= ST_DYA;
                    end
                end
                ST_DYA:
                begin
                    if (u_stat.done)
                    begin
                        da_reg    <= t0_reg[DAW-1:0] + u_result[DAW-1:0];
                        state_reg <= ST_DXB;
                    end
                end
                ST_DXB:
                begin
                    if (u_stat.done)
                    begin
                        t0_reg    <= u_result;
                        state_reg <= ST_DYB;
                    end
                end
                ST_DYB:
                begin
                    if (u_stat.done)
                    begin
                        db_reg    <= t0_reg[DAW-1:0] + u_result[DAW-1:0];
                        state_reg <= ST_PICK;
                    end
                end
                ST_PICK:
                begin
                    res_valid_reg <= 1'b1;
                    res_bal_reg   <= v_reg;
                    if (e_sta[0] && e_sta[1])
                    begin
                        res_found_reg <= 1'b1;
                        res_host_reg  <= pick_b ? e_id[1] : e_id[0];
                        res_rule_reg  <= RULE_NEAREST;
                    end
                    else if (e_sta[0] || e_sta[1])
                    begin
                        res_found_reg <= 1'b1;
                        res_host_reg  <= e_sta[0] ? e_id[0] : e_id[1];
                        res_rule_reg  <= RULE_NEAREST;
                    end
                    else
                    begin
                        res_found_reg <= 1'b0;
                        res_host_reg  <= '0;
                        res_rule_reg  <= RULE_NONE;
                    end
                    count_reg <= '0;
                    lsum_reg  <= '0;
                    lsq_reg   <= '0;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign result_valid   = res_valid_reg;
    assign host_found     = res_found_reg;
    assign chosen_host    = res_host_reg;
    assign rule_used      = res_rule_reg;
    assign balance_degree = res_bal_reg;

    // busy only rises on an accepted final item
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start) && $past(last_host))
        else $error("busy rose without a final item");

    // unit completes only a step it was given
    a_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
        u_stat.done |-> issued_reg && busy)
        else $error("unit done outside a sequencer step");

    a_none_host: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !host_found |-> chosen_host == '0 && rule_used == RULE_NONE)
        else $error("no-host result carries a host");

    a_shortcut_bal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && rule_used == RULE_SHORTCUT |-> balance_degree == '0 && host_found)
        else $error("shortcut result malformed");

endmodule
